FILE: design/tolo_pkg.sv
// ----------------------------------------------------------------------------
// tolo_pkg
// Shared types and constants for the thermostat with overheat lockout.
// ----------------------------------------------------------------------------
package tolo_pkg;

    // Build-time defaults
    localparam int BLINK_TICKS_DEF = 4;
    localparam int TARGET_MAX_DEF  = 99;
    localparam int TARGET_INIT     = 35;

    // Field widths
    localparam int READING_W = 12;
    localparam int WHOLE_W   = 10;
    localparam int FRAC_W    = 7;
    localparam int TARGET_W  = 7;
    localparam int LIMIT_W   = 10;
    localparam int DELTA_W   = 8;
    localparam int HYST_W    = 8;

    // Each quarter degree is 25 hundredths
    localparam logic [FRAC_W-1:0] FRAC_STEP = 7'd25;

    // Register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_HARD_LIMIT    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_RELEASE_DELTA = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_HYSTERESIS    = 4'h8;

    localparam logic [LIMIT_W-1:0] HARD_LIMIT_RST    = 10'd48;
    localparam logic [DELTA_W-1:0] RELEASE_DELTA_RST = 8'd5;
    localparam logic [HYST_W-1:0]  HYSTERESIS_RST    = 8'd1;

    // Item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SET    = 2'd1,
        MODE_LOCK   = 2'd2
    } mode_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] hard_limit;
        logic [DELTA_W-1:0] release_delta;
        logic [HYST_W-1:0]  hysteresis;
    } cfg_t;

    typedef struct packed {
        logic                 cmd;
        logic [READING_W-1:0] raw_reading;
        logic                 up_pressed;
        logic                 down_pressed;
    } item_t;

    typedef struct packed {
        logic                heater_on;
        logic                led_on;
        mode_t               mode;
        logic [WHOLE_W-1:0]  whole_degrees;
        logic [FRAC_W-1:0]   hundredths;
        logic [TARGET_W-1:0] target_degrees;
    } result_t;

endpackage

FILE: design/tolo_apb_regs.sv
// ----------------------------------------------------------------------------
// tolo_apb_regs
// APB register file holding the limit, release delta and hysteresis.
// ----------------------------------------------------------------------------
module tolo_apb_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tolo_pkg::PADDR_W-1:0]   paddr,
    input  logic [tolo_pkg::PDATA_W-1:0]   pwdata,
    output logic [tolo_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output tolo_pkg::cfg_t                 cfg
);

    logic [tolo_pkg::LIMIT_W-1:0] hard_limit_reg;
    logic [tolo_pkg::DELTA_W-1:0] release_delta_reg;
    logic [tolo_pkg::HYST_W-1:0]  hysteresis_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_limit_reg    <= tolo_pkg::HARD_LIMIT_RST;
            release_delta_reg <= tolo_pkg::RELEASE_DELTA_RST;
            hysteresis_reg    <= tolo_pkg::HYSTERESIS_RST;
        end
        else if (wr_en)
        begin
            case (paddr)
                tolo_pkg::ADDR_HARD_LIMIT:
                    hard_limit_reg <= pwdata[tolo_pkg::LIMIT_W-1:0];
                tolo_pkg::ADDR_RELEASE_DELTA:
                    release_delta_reg <= pwdata[tolo_pkg::DELTA_W-1:0];
                tolo_pkg::ADDR_HYSTERESIS:
                    hysteresis_reg <= pwdata[tolo_pkg::HYST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            tolo_pkg::ADDR_HARD_LIMIT:
                prdata = tolo_pkg::PDATA_W'(hard_limit_reg);
            tolo_pkg::ADDR_RELEASE_DELTA:
                prdata = tolo_pkg::PDATA_W'(release_delta_reg);
            tolo_pkg::ADDR_HYSTERESIS:
                prdata = tolo_pkg::PDATA_W'(hysteresis_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.hard_limit    = hard_limit_reg;
    assign cfg.release_delta = release_delta_reg;
    assign cfg.hysteresis    = hysteresis_reg;

endmodule

FILE: design/tolo_core.sv
// ----------------------------------------------------------------------------
// tolo_core
// Mode machine, heater and LED control, and target adjust; one item per step.
// ----------------------------------------------------------------------------
module tolo_core
#(
    parameter int BLINK_TICKS = tolo_pkg::BLINK_TICKS_DEF,
    parameter int TARGET_MAX  = tolo_pkg::TARGET_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tolo_pkg::item_t   item,
    input  tolo_pkg::cfg_t    cfg,
    output tolo_pkg::result_t result
);

    localparam int BlinkW      = (BLINK_TICKS > 1) ? $clog2(BLINK_TICKS) : 1;
    localparam int TargetReset = (tolo_pkg::TARGET_INIT < TARGET_MAX) ?
                                 tolo_pkg::TARGET_INIT : TARGET_MAX;
    localparam logic [tolo_pkg::TARGET_W-1:0] TargetTop = tolo_pkg::TARGET_W'(TARGET_MAX);
    localparam logic [BlinkW-1:0] BlinkLast = BlinkW'(BLINK_TICKS - 1);

    tolo_pkg::mode_t                mode_reg, mode_next;
    tolo_pkg::mode_t                saved_reg, saved_next;
    logic [tolo_pkg::TARGET_W-1:0]  target_reg, target_next;
    logic                           heater_reg, heater_next;
    logic                           led_reg, led_next;
    logic [BlinkW-1:0]              blink_reg, blink_next;

    logic [tolo_pkg::WHOLE_W-1:0]   whole;
    logic [tolo_pkg::FRAC_W-1:0]    frac;
    logic [tolo_pkg::WHOLE_W:0]     whole_plus_hyst;
    logic [tolo_pkg::WHOLE_W:0]     whole_plus_delta;

    assign whole = item.raw_reading[tolo_pkg::READING_W-1:2];
    assign frac  = tolo_pkg::FRAC_W'(item.raw_reading[1:0]) * tolo_pkg::FRAC_STEP;

    assign whole_plus_hyst  = {1'b0, whole} + (tolo_pkg::WHOLE_W+1)'(cfg.hysteresis);
    assign whole_plus_delta = {1'b0, whole} + (tolo_pkg::WHOLE_W+1)'(cfg.release_delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= tolo_pkg::MODE_NORMAL;
            saved_reg  <= tolo_pkg::MODE_NORMAL;
            target_reg <= tolo_pkg::TARGET_W'(TargetReset);
            heater_reg <= 1'b0;
            led_reg    <= 1'b0;
            blink_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            saved_reg  <= saved_next;
            target_reg <= target_next;
            heater_reg <= heater_next;
            led_reg    <= led_next;
            blink_reg  <= blink_next;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        saved_next  = saved_reg;
        target_next = target_reg;
        heater_next = heater_reg;
        led_next    = led_reg;
        blink_next  = blink_reg;

        if (item.cmd == tolo_pkg::CMD_SET)
        begin
            heater_next = 1'b0;
            if (mode_reg != tolo_pkg::MODE_SET)
            begin
                saved_next = mode_reg;
                mode_next  = tolo_pkg::MODE_SET;
                blink_next = '0;
            end
            else
            begin
                mode_next = saved_reg;
                led_next  = (saved_reg == tolo_pkg::MODE_LOCK);
            end
        end
        else
        begin
            case (mode_reg)
                tolo_pkg::MODE_NORMAL:
                begin
                    if (whole >= cfg.hard_limit)
                    begin
                        mode_next   = tolo_pkg::MODE_LOCK;
                        heater_next = 1'b0;
                        led_next    = 1'b1;
                    end
                    else
                    begin
                        // turning on wins when both thresholds hold
                        if (whole >= tolo_pkg::WHOLE_W'(target_reg))
                            heater_next = 1'b0;
                        if (whole_plus_hyst <= (tolo_pkg::WHOLE_W+1)'(target_reg))
                            heater_next = 1'b1;
                    end
                end
                tolo_pkg::MODE_LOCK:
                begin
                    if ((tolo_pkg::WHOLE_W+1)'(cfg.hard_limit) >= whole_plus_delta)
                    begin
                        mode_next = tolo_pkg::MODE_NORMAL;
                        led_next  = 1'b0;
                    end
                end
                default:
                begin
                    heater_next = 1'b0;
                    if (blink_reg == '0)
                        led_next = ~led_reg;
                    blink_next = (blink_reg >= BlinkLast) ? '0 : blink_reg + 1'b1;
                    // up takes priority over down; saturate at both ends
                    if (item.up_pressed)
                    begin
                        if (target_reg < TargetTop)
                            target_next = target_reg + 1'b1;
                    end
                    else if (item.down_pressed)
                    begin
                        if (target_reg != '0)
                            target_next = target_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    assign result.heater_on      = heater_next;
    assign result.led_on         = led_next;
    assign result.mode           = mode_next;
    assign result.whole_degrees  = whole;
    assign result.hundredths     = frac;
    assign result.target_degrees = target_next;

endmodule

FILE: design/thermostat_with_overheat_lockout_top.sv
// ----------------------------------------------------------------------------
// thermostat_with_overheat_lockout_top
// Bang-bang thermostat with set-target mode and over-limit heater lockout.
// Takes one beat per cycle, sustained, while the output is not stalled. A
// beat lands in an input register; when the output slot is free or draining,
// the mode machine updates its state from that register and the result goes
// to an output register in the same cycle. The state update in the core
// sets the rate; the output register lets a new beat enter while a finished
// result still waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
module thermostat_with_overheat_lockout_top
#(
    parameter int BLINK_TICKS = tolo_pkg::BLINK_TICKS_DEF,
    parameter int TARGET_MAX  = tolo_pkg::TARGET_MAX_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // raw_reading[11:0], up_pressed[12], down_pressed[13], zero[15:14]
    input  logic [15:0]                    s_tdata,
    // cmd[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // heater_on[0], led_on[1], mode[3:2], whole_degrees[13:4],
    // hundredths[20:14], target_degrees[27:21], zero[31:28]
    output logic [31:0]                    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tolo_pkg::PADDR_W-1:0]   paddr,
    input  logic [tolo_pkg::PDATA_W-1:0]   pwdata,
    output logic [tolo_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    tolo_pkg::cfg_t    cfg;
    tolo_pkg::item_t   in_item_reg;
    tolo_pkg::result_t result;
    tolo_pkg::result_t out_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              s_accept;
    logic              advance;

    tolo_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tolo_core
    #(
        .BLINK_TICKS (BLINK_TICKS),
        .TARGET_MAX  (TARGET_MAX)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // advance the held beat when the output slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.cmd          <= s_tuser;
            in_item_reg.raw_reading  <= s_tdata[11:0];
            in_item_reg.up_pressed   <= s_tdata[12];
            in_item_reg.down_pressed <= s_tdata[13];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_reg.target_degrees,
                       out_reg.hundredths,
                       out_reg.whole_degrees,
                       out_reg.mode,
                       out_reg.led_on,
                       out_reg.heater_on};

endmodule
